/* hdl/can_traffic_rate_monitor_top_defines.svh */
// Assertion macros used by the CAN traffic rate monitor back end.
`ifndef CAN_TRAFFIC_RATE_MONITOR_TOP_DEFINES_SVH
`define CAN_TRAFFIC_RATE_MONITOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CTRM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ctrm assertion failed");
`define CTRM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctrm implication failed");
`else
`define CTRM_ASSERT(label, clk, rst_n, prop)
`define CTRM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/ctrm_pkg.sv */
// Package with types and constants of the CAN traffic rate monitor.
`timescale 1ns / 1ps
package ctrm_pkg;

    localparam int BUS_W       = 2;
    localparam int DATA_W      = 32;
    localparam int WIN_W       = 16;
    localparam int STAT_KINDS  = 4;
    localparam int KIND_W      = 2;
    localparam int BUS_COUNT_DEF   = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DATA_W-1:0] MS_PER_SEC   = 32'd1000;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd1000;

    localparam int KIND_RX      = 0;
    localparam int KIND_TX_OK   = 1;
    localparam int KIND_TX_FAIL = 2;
    localparam int KIND_FULL    = 3;

    localparam logic CMD_RX = 1'b0;
    localparam logic CMD_TX = 1'b1;

    typedef struct packed {
        logic [BUS_W-1:0]      bus;
        logic                  bus_ok;
        logic [STAT_KINDS-1:0] inc;
        logic [DATA_W-1:0]     now;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } back_state_t;

endpackage

/* hdl/can_traffic_rate_monitor_top.sv */
// Top level of the CAN traffic rate monitor.
// Usage: each input word is one bus event (received frame or transmit result)
// with the current millisecond tick, taken on in_valid and in_ready.
// Each event produces exactly one result word on out_valid and out_ready,
// carrying the bus's four wrapping counters, its four per-second rates
// from the last closed window, and a flag set when this event closed one.
// The window length is written through cfg_valid and window_ms, which are
// always ready; write it only while no events are in flight.
// An event that does not close a window passes from the queue through the
// load and emit states to the result register. One that closes a window also
// passes through multiply, divider start and divider wait for each of the four
// rates first. Events are processed one at a time in arrival order.
// A two-word queue behind the input lets up to two events wait while one is
// being processed. When the receiver stalls, the finished result holds in
// the output register and the back end waits before loading the next one.
// Reset clears all counters, snapshots and rates and sets the window to 1000.
`timescale 1ns / 1ps
module can_traffic_rate_monitor_top #(
    parameter int BUS_COUNT   = ctrm_pkg::BUS_COUNT_DEF,
    parameter int QUEUE_DEPTH = ctrm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ctrm_pkg::WIN_W-1:0]  window_ms,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [ctrm_pkg::BUS_W-1:0]  bus,
    input  logic                        tx_success,
    input  logic                        queue_full,
    input  logic [ctrm_pkg::DATA_W-1:0] now_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ctrm_pkg::BUS_W-1:0]  bus_out,
    output logic [ctrm_pkg::DATA_W-1:0] rx_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_ok_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_fail_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_full_count,
    output logic [ctrm_pkg::DATA_W-1:0] rx_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_ok_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_fail_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_full_rate,
    output logic                        rates_updated
);
    import ctrm_pkg::*;

    logic [WIN_W-1:0] window_reg;
    queue_stat_t      q_stat;
    logic             q_push;
    logic             q_pop;
    item_t            push_item;
    item_t            pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            window_reg <= window_ms;
        end
    end

    assign cfg_ready = 1'b1;

    ctrm_front #(
        .BUS_COUNT (BUS_COUNT)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .bus        (bus),
        .tx_success (tx_success),
        .queue_full (queue_full),
        .now_ms     (now_ms),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    ctrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    ctrm_back #(
        .BUS_COUNT (BUS_COUNT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_ms       (window_reg),
        .q_stat          (q_stat),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bus_out         (bus_out),
        .rx_count        (rx_count),
        .tx_ok_count     (tx_ok_count),
        .tx_fail_count   (tx_fail_count),
        .tx_full_count   (tx_full_count),
        .rx_rate         (rx_rate),
        .tx_ok_rate      (tx_ok_rate),
        .tx_fail_rate    (tx_fail_rate),
        .tx_full_rate    (tx_full_rate),
        .rates_updated   (rates_updated)
    );

endmodule

/* hdl/ctrm_front.sv */
// Front end: accepts event words and classifies them into counter increments.
`timescale 1ns / 1ps
module ctrm_front #(
    parameter int BUS_COUNT = ctrm_pkg::BUS_COUNT_DEF
) (
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [ctrm_pkg::BUS_W-1:0] bus,
    input  logic                       tx_success,
    input  logic                       queue_full,
    input  logic [ctrm_pkg::DATA_W-1:0] now_ms,
    input  ctrm_pkg::queue_stat_t      q_stat,
    output logic                       q_push,
    output ctrm_pkg::item_t            q_item
);
    import ctrm_pkg::*;

    always_comb
    begin
        in_ready = !q_stat.full;
        q_push   = in_valid && !q_stat.full;

        q_item.bus    = bus;
        q_item.bus_ok = (32'(bus) < BUS_COUNT);
        q_item.now    = now_ms;
        q_item.inc    = '0;
        if (command == CMD_RX)
        begin
            q_item.inc[KIND_RX] = 1'b1;
        end
        else if (tx_success)
        begin
            q_item.inc[KIND_TX_OK] = 1'b1;
        end
        else
        begin
            q_item.inc[KIND_TX_FAIL] = 1'b1;
            q_item.inc[KIND_FULL]    = queue_full;
        end
    end

endmodule

/* hdl/ctrm_queue.sv */
// Short queue of classified events between the front and back ends.
`timescale 1ns / 1ps
module ctrm_queue #(
    parameter int DEPTH = ctrm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ctrm_pkg::item_t       push_item,
    input  logic                  pop,
    output ctrm_pkg::item_t       pop_item,
    output ctrm_pkg::queue_stat_t stat
);
    import ctrm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = (32'(count_reg) == DEPTH);
    assign stat.empty = (count_reg == '0);

endmodule

/* hdl/ctrm_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ctrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ctrm_pkg::DATA_W-1:0] dividend,
    input  logic [ctrm_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [ctrm_pkg::DATA_W-1:0] quotient
);
    import ctrm_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        trial   = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (32'(step_reg) == DATA_W - 1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/ctrm_back.sv */
// Back end: per-bus counters, window check, rate computation and result register.
`timescale 1ns / 1ps
module ctrm_back #(
    parameter int BUS_COUNT = ctrm_pkg::BUS_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ctrm_pkg::WIN_W-1:0]  window_ms,
    input  ctrm_pkg::queue_stat_t       q_stat,
    input  ctrm_pkg::item_t             q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ctrm_pkg::BUS_W-1:0]  bus_out,
    output logic [ctrm_pkg::DATA_W-1:0] rx_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_ok_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_fail_count,
    output logic [ctrm_pkg::DATA_W-1:0] tx_full_count,
    output logic [ctrm_pkg::DATA_W-1:0] rx_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_ok_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_fail_rate,
    output logic [ctrm_pkg::DATA_W-1:0] tx_full_rate,
    output logic                        rates_updated
);
    import ctrm_pkg::*;
    `include "can_traffic_rate_monitor_top_defines.svh"

    localparam int BI_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;

    back_state_t state_reg;
    back_state_t state_next;

    item_t             item_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DATA_W-1:0] elapsed_reg;
    logic [DATA_W-1:0] scaled_reg;
    logic              updated_reg;

    logic [DATA_W-1:0] cnt_reg  [BUS_COUNT][STAT_KINDS];
    logic [DATA_W-1:0] snap_reg [BUS_COUNT][STAT_KINDS];
    logic [DATA_W-1:0] rate_reg [BUS_COUNT][STAT_KINDS];
    logic [DATA_W-1:0] time_reg [BUS_COUNT];

    logic              out_valid_reg;
    logic [BUS_W-1:0]  out_bus_reg;
    logic [DATA_W-1:0] out_cnt_reg  [STAT_KINDS];
    logic [DATA_W-1:0] out_rate_reg [STAT_KINDS];
    logic              out_upd_reg;

    logic [BI_W-1:0]   bi;
    logic [DATA_W-1:0] cnt_new [STAT_KINDS];
    logic              snap_zero;
    logic [WIN_W-1:0]  win;
    logic [DATA_W-1:0] elapsed;
    logic              window_closed;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] quotient;

    logic ld_item;
    logic ld_cnt;
    logic snap_first;
    logic mul_en;
    logic rate_we;
    logic snap_final;
    logic out_load;

    always_comb
    begin
        bi        = BI_W'(item_reg.bus);
        snap_zero = (time_reg[bi] == '0);
        win       = (window_ms == '0) ? WIN_W'(1) : window_ms;
        elapsed   = item_reg.now - time_reg[bi];
        window_closed = (elapsed >= {{(DATA_W-WIN_W){1'b0}}, win});
        out_free  = !out_valid_reg || out_ready;
        for (int k = 0; k < STAT_KINDS; k++)
        begin
            cnt_new[k] = cnt_reg[bi][k] + {{(DATA_W-1){1'b0}}, item_reg.inc[k]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (item_reg.bus_ok && !snap_zero && window_closed)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (32'(kind_reg) == STAT_KINDS - 1) ? S_EMIT : S_MUL;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        ld_item    = 1'b0;
        ld_cnt     = 1'b0;
        snap_first = 1'b0;
        mul_en     = 1'b0;
        div_start  = 1'b0;
        rate_we    = 1'b0;
        snap_final = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                q_pop   = !q_stat.empty;
                ld_item = !q_stat.empty;
            end
            S_LOAD:
            begin
                ld_cnt     = item_reg.bus_ok;
                snap_first = item_reg.bus_ok && snap_zero;
            end
            S_MUL:
            begin
                mul_en = 1'b1;
            end
            S_DIV_START:
            begin
                div_start = 1'b1;
            end
            S_DIV_WAIT:
            begin
                rate_we    = div_done;
                snap_final = div_done && (32'(kind_reg) == STAT_KINDS - 1);
            end
            S_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < BUS_COUNT; b++)
            begin
                time_reg[b] <= '0;
                for (int k = 0; k < STAT_KINDS; k++)
                begin
                    cnt_reg[b][k]  <= '0;
                    snap_reg[b][k] <= '0;
                    rate_reg[b][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ld_cnt)
            begin
                for (int k = 0; k < STAT_KINDS; k++)
                begin
                    cnt_reg[bi][k] <= cnt_new[k];
                end
            end
            if (snap_first)
            begin
                time_reg[bi] <= item_reg.now;
                for (int k = 0; k < STAT_KINDS; k++)
                begin
                    snap_reg[bi][k] <= cnt_new[k];
                end
            end
            if (rate_we)
            begin
                rate_reg[bi][kind_reg] <= quotient;
            end
            if (snap_final)
            begin
                time_reg[bi] <= item_reg.now;
                for (int k = 0; k < STAT_KINDS; k++)
                begin
                    snap_reg[bi][k] <= cnt_reg[bi][k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_item)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_LOAD)
        begin
            kind_reg    <= '0;
            elapsed_reg <= elapsed;
            updated_reg <= 1'b0;
        end
        if (mul_en)
        begin
            scaled_reg <= (cnt_reg[bi][kind_reg] - snap_reg[bi][kind_reg]) * MS_PER_SEC;
        end
        if (rate_we)
        begin
            kind_reg <= kind_reg + 1'b1;
        end
        if (snap_final)
        begin
            updated_reg <= 1'b1;
        end
        if (out_load)
        begin
            out_bus_reg <= item_reg.bus;
            out_upd_reg <= item_reg.bus_ok && updated_reg;
            for (int k = 0; k < STAT_KINDS; k++)
            begin
                out_cnt_reg[k]  <= item_reg.bus_ok ? cnt_reg[bi][k] : '0;
                out_rate_reg[k] <= item_reg.bus_ok ? rate_reg[bi][k] : '0;
            end
        end
    end

    ctrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled_reg),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid       = out_valid_reg;
    assign bus_out         = out_bus_reg;
    assign rx_count        = out_cnt_reg[KIND_RX];
    assign tx_ok_count     = out_cnt_reg[KIND_TX_OK];
    assign tx_fail_count   = out_cnt_reg[KIND_TX_FAIL];
    assign tx_full_count   = out_cnt_reg[KIND_FULL];
    assign rx_rate         = out_rate_reg[KIND_RX];
    assign tx_ok_rate      = out_rate_reg[KIND_TX_OK];
    assign tx_fail_rate    = out_rate_reg[KIND_TX_FAIL];
    assign tx_full_rate    = out_rate_reg[KIND_FULL];
    assign rates_updated   = out_upd_reg;

    `CTRM_ASSERT_IMPL(a_div_nonzero, clk, rst_n, div_start, elapsed_reg != '0)
    `CTRM_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, !q_stat.empty)
    `CTRM_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || out_ready)
    `CTRM_ASSERT_IMPL(a_div_only_waiting, clk, rst_n, div_done, state_reg == S_DIV_WAIT)

endmodule
